// ===== design/owsbd_pkg.sv =====
package owsbd_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int MAX_INTERVAL_LOG2 = 12;
    localparam int MIN_INTERVAL_LOG2 = 2;
    localparam int TRIG_FRAC_BITS    = 15;
    localparam int ACC_FRAC          = 8;
    localparam int ACC_W             = 48;
    localparam int LOG_W             = 4;
    localparam int IDX_W             = MAX_INTERVAL_LOG2;
    localparam int POS_W             = MAX_INTERVAL_LOG2 - 1;
    // sine/cosine carry one extra integer bit and a sign bit (1.0 is exact)
    localparam int TRIG_W            = TRIG_FRAC_BITS + 2;
    localparam int BYTE_W            = 8;
    localparam int COEF_W            = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [LOG_W-1:0] INTERVAL_RESET = LOG_W'(8);

    // frame bytes
    localparam logic [BYTE_W-1:0] FRAME_HEAD = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] FRAME_TAIL = BYTE_W'(255);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           phase_idx;  // angle scaled to a full 2^IDX_W circle
        logic [IDX_W-1:0]           win_idx;
        logic [LOG_W-1:0]           log2n;
        logic                       emit;       // send a frame before this sample
    } t_job;

endpackage

// ===== design/owsbd_front.sv =====
module owsbd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic signed [owsbd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [owsbd_pkg::LOG_W-1:0]         i_log2n,
    output logic                                o_push,
    input  logic                                i_push_ready,
    output owsbd_pkg::t_job                     o_job
);

    localparam int IDX_W = owsbd_pkg::IDX_W;
    localparam int POS_W = owsbd_pkg::POS_W;
    localparam int LOG_W = owsbd_pkg::LOG_W;

    logic [POS_W-1:0] r_wpos;
    logic [IDX_W-1:0] r_phase;

    logic [IDX_W:0]   n_pow;
    logic [POS_W:0]   h_pow;
    logic [IDX_W-1:0] nmask;
    logic [POS_W-1:0] hmask;
    logic [POS_W-1:0] wpos;
    logic [IDX_W-1:0] phase;
    logic [LOG_W-1:0] shamt;
    logic             accept;

    assign n_pow = (IDX_W+1)'(1) << i_log2n;
    assign h_pow = (POS_W+1)'(1) << (i_log2n - LOG_W'(1));
    assign nmask = n_pow[IDX_W-1:0] - IDX_W'(1);
    assign hmask = h_pow[POS_W-1:0] - POS_W'(1);

    // counters are folded into the current interval before use
    assign wpos  = r_wpos & hmask;
    assign phase = r_phase & nmask;
    assign shamt = LOG_W'(IDX_W) - i_log2n;

    assign o_s_ready = i_push_ready;
    assign o_push    = i_s_valid;
    assign accept    = i_s_valid && i_push_ready;

    always_comb begin
        o_job.sample    = i_sample;
        o_job.phase_idx = phase << shamt;
        o_job.win_idx   = IDX_W'(wpos) << shamt;
        o_job.log2n     = i_log2n;
        o_job.emit      = (wpos == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_phase <= '0;
        end else if (accept) begin
            r_wpos  <= (wpos + POS_W'(1)) & hmask;
            r_phase <= (phase + IDX_W'(1)) & nmask;
        end
    end

endmodule

// ===== design/owsbd_queue.sv =====
module owsbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  owsbd_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_pop,
    output owsbd_pkg::t_job o_job
);

    localparam int DEPTH = owsbd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    owsbd_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    logic push_fire;
    logic pop_fire;

    assign o_push_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_job        = r_mem[r_rd];
    assign push_fire    = i_push && o_push_ready;
    assign pop_fire     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_fire) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop_fire) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== design/owsbd_trig.sv =====
module owsbd_trig (
    input  logic                                 i_clk,
    input  logic [owsbd_pkg::IDX_W-1:0]          i_idx,
    output logic signed [owsbd_pkg::TRIG_W-1:0]  o_sin,
    output logic signed [owsbd_pkg::TRIG_W-1:0]  o_cos
);

    localparam int IDX_W  = owsbd_pkg::IDX_W;
    localparam int TRIG_W = owsbd_pkg::TRIG_W;
    localparam int FRAC   = owsbd_pkg::TRIG_FRAC_BITS;
    localparam int OCT_W  = IDX_W - 3;          // index bits inside one octant
    localparam int K_W    = OCT_W + 1;          // reflected index reaches a full octant
    localparam int TAB_AW = OCT_W - 1;
    localparam int TAB_N  = 1 << TAB_AW;
    localparam int ENT_W  = FRAC + 1;           // one magnitude, 0 .. 1.0

    localparam logic [63:0] PI4_Q30 = 64'd843314857;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic [2*ENT_W-1:0] t_trig_tab [TAB_N];

    // octant-reduced sine/cosine, Taylor series to x^13 (sine) and x^12 (cosine) in Q2.30
    function automatic logic [2*ENT_W-1:0] trig_entry(input logic [K_W-1:0] k);
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] cc;
        logic signed [63:0] s_out;
        logic signed [63:0] c_out;
        th = ((64'(k) << (29 - OCT_W)) * PI4_Q30) >> 29;
        x2 = (th * th + (64'd1 << 29)) >> 30;
        ts = th;
        tc = ONE_Q30;
        ss = $signed(th);
        cc = $signed(ONE_Q30);
        for (int j = 1; j <= 6; j++) begin
            ts = ((ts * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * j - 1) * (2 * j));
            if ((j & 1) == 1) begin
                ss = ss - $signed(ts);
                cc = cc - $signed(tc);
            end else begin
                ss = ss + $signed(ts);
                cc = cc + $signed(tc);
            end
        end
        if (ss < 0) begin
            ss = '0;
        end
        if (cc < 0) begin
            cc = '0;
        end
        s_out = (ss + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        c_out = (cc + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        return {s_out[ENT_W-1:0], c_out[ENT_W-1:0]};
    endfunction

    function automatic t_trig_tab trig_tab(input logic hi);
        t_trig_tab tab;
        for (int i = 0; i < TAB_N; i++) begin
            tab[i] = trig_entry({1'b0, hi, TAB_AW'(i)});
        end
        return tab;
    endfunction

    localparam t_trig_tab           TRIG_LO  = trig_tab(1'b0);
    localparam t_trig_tab           TRIG_HI  = trig_tab(1'b1);
    localparam logic [2*ENT_W-1:0]  TRIG_END = trig_entry(K_W'(1) << OCT_W);

    logic [2:0]         oct;
    logic [OCT_W-1:0]   frac_idx;
    logic [K_W-1:0]     k;
    logic [2*ENT_W-1:0] ent;
    logic [2*ENT_W-1:0] r_ent;
    logic [2:0]         r_oct;
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] c0;

    assign oct      = i_idx[IDX_W-1 -: 3];
    assign frac_idx = i_idx[OCT_W-1:0];
    // odd octants run backwards from the next multiple of pi/4
    assign k = oct[0] ? ((K_W'(1) << OCT_W) - K_W'(frac_idx)) : K_W'(frac_idx);

    always_comb begin
        if (k[K_W-1]) begin
            ent = TRIG_END;
        end else if (k[OCT_W-1]) begin
            ent = TRIG_HI[k[TAB_AW-1:0]];
        end else begin
            ent = TRIG_LO[k[TAB_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= ent;
        r_oct <= oct;
    end

    assign s0 = $signed({1'b0, r_ent[2*ENT_W-1:ENT_W]});
    assign c0 = $signed({1'b0, r_ent[ENT_W-1:0]});

    always_comb begin
        case (r_oct)
            3'd0: begin o_sin = s0;  o_cos = c0;  end
            3'd1: begin o_sin = c0;  o_cos = s0;  end
            3'd2: begin o_sin = c0;  o_cos = -s0; end
            3'd3: begin o_sin = s0;  o_cos = -c0; end
            3'd4: begin o_sin = -s0; o_cos = -c0; end
            3'd5: begin o_sin = -c0; o_cos = -s0; end
            3'd6: begin o_sin = -c0; o_cos = s0;  end
            default: begin o_sin = -s0; o_cos = c0; end
        endcase
    end

endmodule

// ===== design/owsbd_back.sv =====
module owsbd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    output logic                            o_job_pop,
    input  owsbd_pkg::t_job                 i_job,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [owsbd_pkg::BYTE_W-1:0]    o_tdata,
    output logic                            o_tlast
);

    localparam int SAMPLE_W = owsbd_pkg::SAMPLE_W;
    localparam int TRIG_W   = owsbd_pkg::TRIG_W;
    localparam int FRAC     = owsbd_pkg::TRIG_FRAC_BITS;
    localparam int ACC_FRAC = owsbd_pkg::ACC_FRAC;
    localparam int ACC_W    = owsbd_pkg::ACC_W;
    localparam int COEF_W   = owsbd_pkg::COEF_W;
    localparam int BYTE_W   = owsbd_pkg::BYTE_W;
    localparam int TS_W     = SAMPLE_W + ACC_FRAC + 1;
    localparam int WGT_W    = FRAC + 3;
    localparam int PROD_W   = TS_W + WGT_W;
    localparam int TS_SH    = FRAC - ACC_FRAC;
    localparam int SH_W     = $clog2(FRAC + owsbd_pkg::MAX_INTERVAL_LOG2 + 1);

    localparam logic signed [WGT_W-1:0]  WGT_ONE  = WGT_W'(1) << FRAC;
    localparam logic signed [PROD_W-1:0] TS_HALF  = PROD_W'(1) << (TS_SH - 1);
    localparam logic signed [ACC_W-1:0]  COEF_MAX = ACC_W'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]  COEF_MIN = -(ACC_W'(1) << (COEF_W - 1));
    localparam logic signed [ACC_W-1:0]  TRUNC_BIAS = ACC_W'((1 << ACC_FRAC) - 1);

    // sequencer steps
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TRIG_W = 4'd1;
    localparam logic [3:0] ST_MUL_S  = 4'd2;
    localparam logic [3:0] ST_MUL_C  = 4'd3;
    localparam logic [3:0] ST_MUL_SP = 4'd4;
    localparam logic [3:0] ST_MUL_CP = 4'd5;
    localparam logic [3:0] ST_MUL_SM = 4'd6;
    localparam logic [3:0] ST_MUL_CM = 4'd7;
    localparam logic [3:0] ST_ACC_S2 = 4'd8;
    localparam logic [3:0] ST_ACC_C2 = 4'd9;

    // frame byte slots
    localparam logic [2:0] BYTE_HEAD   = 3'd0;
    localparam logic [2:0] BYTE_SIN_HI = 3'd1;
    localparam logic [2:0] BYTE_SIN_LO = 3'd2;
    localparam logic [2:0] BYTE_COS_HI = 3'd3;
    localparam logic [2:0] BYTE_COS_LO = 3'd4;
    localparam logic [2:0] BYTE_TAIL   = 3'd5;

    function automatic logic [COEF_W-1:0] coef16(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        // divide by 2^ACC_FRAC rounding toward zero, then saturate
        v = acc + (acc[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0));
        v = v >>> ACC_FRAC;
        if (v > COEF_MAX) begin
            return COEF_MAX[COEF_W-1:0];
        end else if (v < COEF_MIN) begin
            return COEF_MIN[COEF_W-1:0];
        end
        return v[COEF_W-1:0];
    endfunction

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    owsbd_pkg::t_job r_job;

    logic signed [TRIG_W-1:0] r_s;
    logic signed [TRIG_W-1:0] r_c;
    logic signed [WGT_W-1:0]  r_wp;
    logic signed [WGT_W-1:0]  r_wm;
    logic signed [TS_W-1:0]   r_ts;
    logic signed [TS_W-1:0]   r_tc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_term;
    logic signed [ACC_W-1:0]  r_acc [4];

    logic                     r_frm_active;
    logic [2:0]               r_fidx;
    logic [COEF_W-1:0]        r_sv;
    logic [COEF_W-1:0]        r_cv;
    logic                     r_ovalid;
    logic [BYTE_W-1:0]        r_odata;
    logic                     r_olast;

    logic                     start;
    logic [owsbd_pkg::IDX_W-1:0] trig_idx;
    logic signed [TRIG_W-1:0] trig_sin;
    logic signed [TRIG_W-1:0] trig_cos;
    logic signed [TS_W-1:0]   mul_a;
    logic signed [WGT_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] ts_shift;
    logic [SH_W-1:0]          term_sh;
    logic signed [PROD_W-1:0] term_half;
    logic signed [PROD_W-1:0] term_shift;
    logic signed [TS_W-1:0]   sample_x;
    logic                     load_ok;
    logic [BYTE_W-1:0]        frm_byte;

    assign start     = (r_state == ST_IDLE) && !r_frm_active && i_job_valid;
    assign o_job_pop = start;

    // phase angle is looked up while the job is popped, window angle in the following cycle
    assign trig_idx = (r_state == ST_IDLE) ? i_job.phase_idx : r_job.win_idx;

    owsbd_trig u_trig (
        .i_clk (i_clk),
        .i_idx (trig_idx),
        .o_sin (trig_sin),
        .o_cos (trig_cos)
    );

    assign sample_x = {{(TS_W-SAMPLE_W){r_job.sample[SAMPLE_W-1]}}, r_job.sample};

    always_comb begin
        case (r_state)
            ST_MUL_S: begin
                mul_a = sample_x;
                mul_b = {{(WGT_W-TRIG_W){r_s[TRIG_W-1]}}, r_s};
            end
            ST_MUL_C: begin
                mul_a = sample_x;
                mul_b = {{(WGT_W-TRIG_W){r_c[TRIG_W-1]}}, r_c};
            end
            ST_MUL_SP: begin mul_a = r_ts; mul_b = r_wp; end
            ST_MUL_CP: begin mul_a = r_tc; mul_b = r_wp; end
            ST_MUL_SM: begin mul_a = r_ts; mul_b = r_wm; end
            ST_MUL_CM: begin mul_a = r_tc; mul_b = r_wm; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign ts_shift   = (r_prod + TS_HALF) >>> TS_SH;
    assign term_sh    = SH_W'(FRAC) + SH_W'(r_job.log2n);
    assign term_half  = PROD_W'(1) << (term_sh - SH_W'(1));
    assign term_shift = (r_prod + term_half) >>> term_sh;

    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = start ? ST_TRIG_W : ST_IDLE;
            ST_ACC_C2: n_state = ST_IDLE;
            default:   n_state = r_state + 4'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job <= i_job;
        end
        if (r_state == ST_TRIG_W) begin
            r_s <= trig_sin;
            r_c <= trig_cos;
        end
        if (r_state == ST_MUL_S) begin
            r_wp <= WGT_ONE + {{(WGT_W-TRIG_W){trig_cos[TRIG_W-1]}}, trig_cos};
            r_wm <= WGT_ONE - {{(WGT_W-TRIG_W){trig_cos[TRIG_W-1]}}, trig_cos};
        end
        if (r_state == ST_MUL_C) begin
            r_ts <= ts_shift[TS_W-1:0];
        end
        if (r_state == ST_MUL_SP) begin
            r_tc <= ts_shift[TS_W-1:0];
        end
        r_prod <= mul_a * mul_b;
        r_term <= {{(ACC_W-PROD_W){term_shift[PROD_W-1]}}, term_shift};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (start && i_job.emit) begin
                r_acc[0] <= r_acc[2];
                r_acc[1] <= r_acc[3];
                r_acc[2] <= '0;
                r_acc[3] <= '0;
            end
            case (r_state)
                ST_MUL_SM: r_acc[0] <= r_acc[0] + r_term;
                ST_MUL_CM: r_acc[1] <= r_acc[1] + r_term;
                ST_ACC_S2: r_acc[2] <= r_acc[2] + r_term;
                ST_ACC_C2: r_acc[3] <= r_acc[3] + r_term;
                default: ;
            endcase
        end
    end

    // frame sender: runs beside the arithmetic, output register decouples the sink
    assign load_ok = !r_ovalid || i_tready;

    always_comb begin
        case (r_fidx)
            BYTE_HEAD:   frm_byte = owsbd_pkg::FRAME_HEAD;
            BYTE_SIN_HI: frm_byte = r_sv[COEF_W-1:BYTE_W];
            BYTE_SIN_LO: frm_byte = r_sv[BYTE_W-1:0];
            BYTE_COS_HI: frm_byte = r_cv[COEF_W-1:BYTE_W];
            BYTE_COS_LO: frm_byte = r_cv[BYTE_W-1:0];
            BYTE_TAIL:   frm_byte = owsbd_pkg::FRAME_TAIL;
            default:     frm_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start && i_job.emit) begin
            r_sv <= coef16(r_acc[0]);
            r_cv <= coef16(r_acc[1]);
        end
        if (r_frm_active && load_ok) begin
            r_odata <= frm_byte;
            r_olast <= (r_fidx == BYTE_TAIL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_active <= 1'b0;
            r_fidx       <= BYTE_HEAD;
            r_ovalid     <= 1'b0;
        end else begin
            if (start && i_job.emit) begin
                r_frm_active <= 1'b1;
                r_fidx       <= BYTE_HEAD;
            end else if (r_frm_active && load_ok) begin
                r_fidx <= r_fidx + 3'd1;
                if (r_fidx == BYTE_TAIL) begin
                    r_frm_active <= 1'b0;
                end
            end
            if (r_frm_active && load_ok) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

endmodule

// ===== design/overlapped_windowed_single_bin_dft.sv =====
// A sample that opens a window starts a frame whose first byte shows after the queue and
// the output register; the six bytes follow one per cycle while m_axis_tready is high.
// The arithmetic sequencer runs six products and four accumulations through one shared
// multiplier and takes a sample only when idle with no frame pending; a two-entry queue
// lets the input run up to two samples ahead. Reset (i_rst_n low, synchronous) clears
// the counters, accumulators, queue and output, and sets interval_log2 to 8.
module overlapped_windowed_single_bin_dft (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    // frame byte output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    localparam int LOG_W  = owsbd_pkg::LOG_W;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_INTERVAL = '0;

    logic [LOG_W-1:0] r_interval;
    logic [LOG_W-1:0] log2n;
    logic             cfg_wr;
    logic             push;
    logic             push_ready;
    owsbd_pkg::t_job  push_job;
    logic             job_valid;
    logic             job_pop;
    owsbd_pkg::t_job  head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_INTERVAL);
    assign prdata = (paddr[ADDR_W-1:2] == REG_INTERVAL) ? {{(32-LOG_W){1'b0}}, r_interval}
                                                         : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= owsbd_pkg::INTERVAL_RESET;
        end else if (cfg_wr) begin
            r_interval <= pwdata[LOG_W-1:0];
        end
    end

    always_comb begin
        if (r_interval < LOG_W'(owsbd_pkg::MIN_INTERVAL_LOG2)) begin
            log2n = LOG_W'(owsbd_pkg::MIN_INTERVAL_LOG2);
        end else if (r_interval > LOG_W'(owsbd_pkg::MAX_INTERVAL_LOG2)) begin
            log2n = LOG_W'(owsbd_pkg::MAX_INTERVAL_LOG2);
        end else begin
            log2n = r_interval;
        end
    end

    owsbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_sample     ($signed(s_axis_tdata)),
        .i_log2n      (log2n),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_job        (push_job)
    );

    owsbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_job        (push_job),
        .o_valid      (job_valid),
        .i_pop        (job_pop),
        .o_job        (head_job)
    );

    owsbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (head_job),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

// ===== design/owsbd_checker.sv =====
module owsbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [31:0] prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_tail_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'hFF)
        else $error("frame closed on a byte other than the tail marker");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_cfg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[31:4] == 28'd0)
        else $error("register read shows bits beyond the interval field");

endmodule

bind overlapped_windowed_single_bin_dft owsbd_checker u_owsbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .prdata        (prdata)
);
